// ----- rtl/vcc_pkg.sv -----
// ----------------------------------------------------------------------------
// vcc_pkg: shared definitions for the unsigned varint codec
// Result kinds, request codes, byte-field masks, mode limits and the
// sequencer state type.
// ----------------------------------------------------------------------------
package vcc_pkg;

	localparam int ValueWidth = 64;
	localparam int CountWidth = 4;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_VALUE = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	localparam logic REQ_ENCODE = 1'b0;
	localparam logic REQ_DECODE = 1'b1;

	localparam logic [7:0] DATA_MASK = 8'b0111_1111;
	localparam logic [7:0] CONT_BIT  = 8'b1000_0000;

	localparam logic [CountWidth-1:0] LIMIT_SHORT = 4'd5;
	localparam logic [CountWidth-1:0] LIMIT_LONG  = 4'd10;
	localparam logic [CountWidth-1:0] MAX_GROUP   = 4'd9;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_ENC  = 2'b10
	} state_t;

endpackage

// ----- rtl/varint_codec_core.sv -----
// ----------------------------------------------------------------------------
// varint_codec_core: unsigned LEB128 varint encoder and decoder
// Encodes a value into 7-bit groups with a continuation flag, or gathers
// one incoming byte per item into a value, in 32-bit or 64-bit mode.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Payload
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | tuser: req_type; tdata: value_in, byte_in
//  m_axis   | out       | tuser: kind; tdata: byte_out, value_out, byte_count;
//           |           | tlast: last
//  cfg      | in        | data: long_mode
//
// A decode beat is handled in the cycle it is accepted; its result, if any,
// is loaded into the output register at that edge.
// An encode beat loads the shift register, then emits one byte per cycle
// while the sink takes them (1 to 10) through the shared shift-by-seven unit.
// The input is held off while an encode runs or while the output register
// holds a beat the sink has not taken; a stalled sink freezes the sequencer.
// Reset clears the mode, the decoder state and the output valid flag.
//
module varint_codec_core
	import vcc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // [63:0] value_in, [71:64] byte_in
	input  logic        s_axis_tuser,  // [0] req_type

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,  // [7:0] byte_out, [71:8] value_out,
	                                   // [75:72] byte_count, [79:76] zero
	output logic [1:0]  m_axis_tuser,  // [1:0] kind
	output logic        m_axis_tlast,  // last

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data       // long_mode
);

	state_t                state_q;
	logic                  long_mode_q;
	logic [ValueWidth-1:0] work_q;
	logic [CountWidth-1:0] enc_count_q;
	logic [ValueWidth-1:0] accum_q;
	logic [CountWidth-1:0] dec_count_q;

	logic                  out_valid_q;
	kind_t                 out_kind_q;
	logic [7:0]            out_byte_q;
	logic [ValueWidth-1:0] out_value_q;
	logic [CountWidth-1:0] out_count_q;
	logic                  out_last_q;

	logic                  slot_free;
	logic                  in_fire;
	logic                  out_load;
	logic [ValueWidth-1:0] value_in;
	logic [7:0]            byte_in;

	logic [ValueWidth-1:0] enc_rest;
	logic                  enc_more;
	logic [7:0]            enc_byte;

	logic [CountWidth-1:0] dec_group;
	logic [5:0]            dec_shamt;
	logic [ValueWidth-1:0] dec_accum;
	logic [CountWidth-1:0] dec_next;
	logic                  dec_done;
	logic [CountWidth-1:0] limit;

	assign value_in = s_axis_tdata[63:0];
	assign byte_in  = s_axis_tdata[71:64];

	assign slot_free     = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && slot_free;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	assign limit = long_mode_q ? LIMIT_LONG : LIMIT_SHORT;

	// Shared shift unit: peel off the low group and move the rest down.
	assign enc_rest = work_q >> 7;
	assign enc_more = (enc_rest != '0);
	assign enc_byte = (work_q[7:0] & DATA_MASK) | (enc_more ? CONT_BIT : 8'd0);

	// The group position saturates at the tenth byte; bits beyond 64 fall off.
	assign dec_group = (dec_count_q > MAX_GROUP) ? MAX_GROUP : dec_count_q;
	assign dec_shamt = 6'(dec_group) * 6'd7;
	assign dec_accum = accum_q | ({56'd0, byte_in & DATA_MASK} << dec_shamt);
	assign dec_next  = dec_group + 4'd1;
	assign dec_done  = ((byte_in & CONT_BIT) == 8'd0) || (dec_next >= limit);

	// A result beat is loaded for every encoded byte and for a finished decode.
	assign out_load = ((state_q == ST_ENC) && slot_free)
		|| (in_fire && s_axis_tuser == REQ_DECODE && dec_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			long_mode_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			accum_q     <= '0;
			dec_count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire && s_axis_tuser == REQ_ENCODE) begin
						state_q <= ST_ENC;
					end else if (in_fire) begin
						if (dec_done) begin
							accum_q     <= '0;
							dec_count_q <= '0;
						end else begin
							accum_q     <= dec_accum;
							dec_count_q <= dec_next;
						end
					end
				end
				ST_ENC: begin
					if (slot_free && !enc_more) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: shift register and output payload.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire && s_axis_tuser == REQ_ENCODE) begin
					work_q      <= long_mode_q ? value_in : {32'd0, value_in[31:0]};
					enc_count_q <= '0;
				end else if (in_fire) begin
					out_byte_q  <= 8'd0;
					out_count_q <= dec_next;
					out_last_q  <= 1'b1;
					if ((byte_in & CONT_BIT) == 8'd0) begin
						out_kind_q  <= KIND_VALUE;
						out_value_q <= long_mode_q ? dec_accum : {32'd0, dec_accum[31:0]};
					end else begin
						out_kind_q  <= KIND_ERROR;
						out_value_q <= '0;
					end
				end
			end
			ST_ENC: begin
				if (slot_free) begin
					work_q      <= enc_rest;
					enc_count_q <= enc_count_q + 4'd1;
					out_kind_q  <= KIND_BYTE;
					out_byte_q  <= enc_byte;
					out_value_q <= '0;
					out_count_q <= enc_count_q + 4'd1;
					out_last_q  <= !enc_more;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_count_q, out_value_q, out_byte_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// ----- verif/varint_codec_core_tb.sv -----
// ----------------------------------------------------------------------------
// varint_codec_core_tb: self-checking bench for the unsigned varint codec
// Streams encode and decode requests through the core, predicts every
// output beat from a behavioral codec model kept in step with the mode
// register, and compares each beat field by field under random back-pressure.
// ----------------------------------------------------------------------------
module varint_codec_core_tb
	import vcc_pkg::*;
();

	localparam int CycleLimit  = 400000;
	localparam int DrainCycles = 16;
	localparam int RandomItems = 130;

	typedef struct {
		logic        req;
		logic [63:0] value;
		logic [7:0]  data_byte;
	} codec_req_t;

	typedef struct {
		kind_t       kind;
		logic [7:0]  data_byte;
		logic [63:0] value;
		logic [3:0]  count;
		logic        last;
	} codec_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata = '0;   // [63:0] value_in, [71:64] byte_in
	logic        s_axis_tuser = 1'b0; // [0] req_type

	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;        // [7:0] byte_out, [71:8] value_out,
	                                  // [75:72] byte_count, [79:76] zero
	logic [1:0]  m_axis_tuser;        // [1:0] kind
	logic        m_axis_tlast;        // last

	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;     // long_mode

	codec_req_t  codec_requests[$];
	codec_out_t  expected_codec_out[$];

	logic        in_fire = 1'b0;
	logic        cfg_fire = 1'b0;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          fail_count = 0;
	int          cycle_count = 0;

	// Shadow of the core's mode register and decoder state.
	logic        mirror_long = 1'b0;
	logic [63:0] mirror_accum = '0;
	logic [3:0]  mirror_count = '0;

	varint_codec_core uut (.*);

	always #5 clk = ~clk;

	function automatic void queue_encode(logic [63:0] value);
		codec_requests.push_back('{req: REQ_ENCODE, value: value, data_byte: 8'($urandom)});
	endfunction

	function automatic void queue_decode(logic [7:0] data_byte);
		codec_requests.push_back('{req: REQ_DECODE, value: {$urandom, $urandom},
			data_byte: data_byte});
	endfunction

	// Random value with a random significant width, so every encoded length shows up.
	function automatic logic [63:0] rand_value();
		logic [63:0] v;
		int unsigned w;
		v = {$urandom, $urandom};
		w = $urandom_range(64);
		if (w < 64) begin
			v = v & ((64'd1 << w) - 64'd1);
		end
		return v;
	endfunction

	// Mostly well-formed encoded values with random payload; some overlong runs,
	// some stray bytes, and encodes dropped into the middle of a value.
	function automatic void queue_random_traffic(int n_items, logic long_mode);
		int added;
		int len;
		int pick;
		logic [3:0] limit;
		logic [7:0] b;
		limit = long_mode ? LIMIT_LONG : LIMIT_SHORT;
		added = 0;
		while (added < n_items) begin
			pick = $urandom_range(99);
			if (pick < 30) begin
				queue_encode(rand_value());
				added++;
			end else if (pick < 80) begin
				len = $urandom_range(limit, 1);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(9) == 0) begin
						queue_encode(rand_value());
						added++;
					end
					b = 8'($urandom);
					b[7] = (i < len - 1);
					queue_decode(b);
					added++;
				end
			end else if (pick < 90) begin
				for (int i = 0; i < limit; i++) begin
					b = 8'($urandom) | CONT_BIT;
					queue_decode(b);
					added++;
				end
			end else begin
				len = $urandom_range(3, 1);
				for (int i = 0; i < len; i++) begin
					queue_decode(8'($urandom));
					added++;
				end
			end
		end
	endfunction

	function automatic void compute_codec_results(logic req, logic [63:0] value,
			logic [7:0] data_byte);
		logic [63:0] rest;
		logic [63:0] result;
		logic [3:0]  limit;
		logic [3:0]  grp;
		logic [3:0]  used;
		logic        more;
		int          emitted;
		limit = mirror_long ? LIMIT_LONG : LIMIT_SHORT;
		if (req == REQ_ENCODE) begin
			rest = mirror_long ? value : {32'd0, value[31:0]};
			emitted = 0;
			do begin
				more = (rest >> 7) != 64'd0;
				expected_codec_out.push_back('{kind: KIND_BYTE,
					data_byte: {more, rest[6:0]}, value: 64'd0,
					count: 4'(emitted + 1), last: !more});
				rest = rest >> 7;
				emitted++;
			end while (more && emitted < LIMIT_LONG);
		end else begin
			grp = (mirror_count > MAX_GROUP) ? MAX_GROUP : mirror_count;
			mirror_accum = mirror_accum | (64'(data_byte & DATA_MASK) << (7 * grp));
			used = grp + 4'd1;
			if ((data_byte & CONT_BIT) == 8'd0) begin
				result = mirror_long ? mirror_accum : {32'd0, mirror_accum[31:0]};
				expected_codec_out.push_back('{kind: KIND_VALUE, data_byte: 8'd0,
					value: result, count: used, last: 1'b1});
				mirror_accum = '0;
				mirror_count = '0;
			end else if (used >= limit) begin
				expected_codec_out.push_back('{kind: KIND_ERROR, data_byte: 8'd0,
					value: 64'd0, count: used, last: 1'b1});
				mirror_accum = '0;
				mirror_count = '0;
			end else begin
				mirror_count = used;
			end
		end
	endfunction

	function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : monitor
		codec_out_t want;
		if (!arst_n) begin
			in_fire <= 1'b0;
			cfg_fire <= 1'b0;
		end else begin
			in_fire <= s_axis_tvalid && s_axis_tready;
			cfg_fire <= cfg_valid && cfg_ready;
			if (cfg_valid && cfg_ready) begin
				mirror_long = cfg_data;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_codec_out.size() == 0) begin
					$display("%0t: unexpected beat, expected none, %s %0d tdata 0x%0h last %0b",
						$time, "actual kind", m_axis_tuser, m_axis_tdata, m_axis_tlast);
					fail_count++;
				end else begin
					want = expected_codec_out.pop_front();
					check_field("kind", 64'(want.kind), 64'(m_axis_tuser));
					check_field("byte_out", 64'(want.data_byte), 64'(m_axis_tdata[7:0]));
					check_field("value_out", want.value, m_axis_tdata[71:8]);
					check_field("byte_count", 64'(want.count), 64'(m_axis_tdata[75:72]));
					check_field("tdata padding", 64'd0, 64'(m_axis_tdata[79:76]));
					check_field("last", 64'(want.last), 64'(m_axis_tlast));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				compute_codec_results(s_axis_tuser, s_axis_tdata[63:0], s_axis_tdata[71:64]);
			end
		end
	end

	always @(negedge clk) begin : driver
		codec_req_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || in_fire) begin
			if (codec_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = codec_requests.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= nxt.req;
				s_axis_tdata <= {nxt.data_byte, nxt.value};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic write_long_mode(input logic mode);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= mode;
		do @(negedge clk); while (!cfg_fire);
		cfg_valid <= 1'b0;
	endtask

	// An encode may still be shifting out bytes after the queue looks empty,
	// and trailing continuation bytes produce no beat, hence the extra cycles.
	task automatic wait_until_drained();
		while (codec_requests.size() != 0 || s_axis_tvalid
				|| expected_codec_out.size() != 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 31;
		stall_pct = 66;

		// 32-bit mode: zero, truncated all-ones, overlong, encode in the middle
		// of a value, and a fifth byte carrying bits past bit 31.
		write_long_mode(1'b0);
		queue_encode(64'd0);
		queue_encode(64'hFFFF_FFFF_FFFF_FFFF);
		queue_decode(8'h00);
		repeat (5) queue_decode(8'hFF);
		repeat (2) queue_decode(8'hFF);
		queue_encode(64'h7F);
		repeat (2) queue_decode(8'hFF);
		queue_decode(8'h7F);
		repeat (3) queue_decode(8'h80);
		wait_until_drained();

		// Switch to 64-bit mode with three bytes already gathered, then finish a
		// ten-byte value whose last byte has bits past bit 63.
		write_long_mode(1'b1);
		repeat (6) queue_decode(8'hFF);
		queue_decode(8'h7F);
		queue_encode(64'hFFFF_FFFF_FFFF_FFFF);
		repeat (5) queue_decode(8'hFF);
		wait_until_drained();

		// Five bytes held when the limit drops to five: next continuation is overlong.
		write_long_mode(1'b0);
		queue_decode(8'hFF);
		wait_until_drained();

		write_long_mode(1'b1);
		queue_random_traffic(RandomItems, 1'b1);
		wait_until_drained();

		send_idle_pct = 66;
		stall_pct = 31;
		write_long_mode(1'b0);
		queue_random_traffic(RandomItems, 1'b0);
		wait_until_drained();

		send_idle_pct = 0;
		stall_pct = 0;
		write_long_mode(1'b1);
		queue_random_traffic(RandomItems, 1'b1);
		wait_until_drained();

		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
